### src/lcpe_pkg.sv
`timescale 1ns / 1ps

package lcpe_pkg;

    localparam int NUM_LEDS    = 20;
    localparam int RESET_SLOTS = 50;

    localparam int FRAME_BYTES = 3 * NUM_LEDS;
    localparam int DATA_SLOTS  = 8 * FRAME_BYTES;
    localparam int TOTAL_SLOTS = DATA_SLOTS + RESET_SLOTS;

    // fixed field widths
    localparam int KIND_W  = 2;
    localparam int INDEX_W = 6;
    localparam int BYTE_W  = 8;
    localparam int TICK_W  = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    localparam int ADDR_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int SLOT_W = $clog2(TOTAL_SLOTS + 1);

    localparam logic [TICK_W-1:0] SLOW_PERIOD = TICK_W'(105);
    localparam logic [TICK_W-1:0] SLOW_T0H    = TICK_W'(21);
    localparam logic [TICK_W-1:0] SLOW_T1H    = TICK_W'(50);
    localparam logic [TICK_W-1:0] FAST_PERIOD = TICK_W'(60);
    localparam logic [TICK_W-1:0] FAST_T0H    = TICK_W'(12);
    localparam logic [TICK_W-1:0] FAST_T1H    = TICK_W'(29);

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 2'd0,
        KIND_START = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FAST_MODE       = 1'b0,
        CFG_INVERT_POLARITY = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_APPLY = 3'b010,
        ST_LEVEL = 3'b100
    } state_t;

endpackage

### src/lcpe_ram.sv
`timescale 1ns / 1ps

module lcpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/led_chain_pulse_encoder.sv
`timescale 1ns / 1ps

// Serial transmitter for a WS2811 LED chain. Each item (write color byte,
// start frame, or one timer tick) goes through accept, frame store update
// and read, then level evaluation from the registered read data; busy is
// high in the apply and level states and done pulses for one cycle with
// line_level and ready_res. The frame store needs no clearing pass: per-byte
// valid bits make unwritten bytes read as zero right after reset. done cannot
// be stalled; the receiver must take every result in its strobe cycle.
module led_chain_pulse_encoder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    output logic                           done,
    input  logic [lcpe_pkg::KIND_W-1:0]    kind,
    input  logic [lcpe_pkg::INDEX_W-1:0]   byte_index,
    input  logic [lcpe_pkg::BYTE_W-1:0]    color_byte,
    output logic                           line_level,
    output logic                           ready_res,
    input  logic                           cfg_we,
    input  logic [lcpe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lcpe_pkg::CFG_DATA_W-1:0] cfg_data
);

    lcpe_pkg::state_t state_reg, state_next;

    // latched item
    logic [lcpe_pkg::KIND_W-1:0]  kind_reg;
    logic [lcpe_pkg::INDEX_W-1:0] idx_reg;
    logic [lcpe_pkg::BYTE_W-1:0]  color_reg;

    // configuration
    logic fast_mode_reg;
    logic invert_reg;

    // frame sequencer
    logic                          active_reg, active_next;
    logic [lcpe_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [lcpe_pkg::TICK_W-1:0]   tick_reg, tick_next;
    logic [lcpe_pkg::FRAME_BYTES-1:0] valid_reg, valid_next;

    // position whose level is reported
    logic                          lvl_active_reg, lvl_active_next;
    logic [lcpe_pkg::SLOT_W-1:0]   lvl_slot_reg, lvl_slot_next;
    logic [lcpe_pkg::TICK_W-1:0]   lvl_tick_reg, lvl_tick_next;
    logic                          rd_valid_reg, rd_valid_next;

    logic done_reg, level_reg, ready_reg;
    logic done_next, level_next, ready_next;

    logic                          ram_we;
    logic [lcpe_pkg::ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [lcpe_pkg::BYTE_W-1:0]   ram_rdata;
    logic [lcpe_pkg::TICK_W-1:0]   period;
    logic [lcpe_pkg::TICK_W-1:0]   high_ticks;
    logic [2:0]                    bit_sel;
    logic                          data_bit;
    logic                          raw_level;
    logic [lcpe_pkg::SLOT_W-1:0]   slot_inc;
    logic                          accept;

    assign accept = start && !busy;
    assign busy   = (state_reg != lcpe_pkg::ST_IDLE);
    assign done       = done_reg;
    assign line_level = level_reg;
    assign ready_res  = ready_reg;

    assign period   = fast_mode_reg ? lcpe_pkg::FAST_PERIOD : lcpe_pkg::SLOW_PERIOD;
    assign slot_inc = slot_reg + lcpe_pkg::SLOT_W'(1);

    assign ram_waddr = lcpe_pkg::ADDR_W'(idx_reg);
    assign ram_raddr = lcpe_pkg::ADDR_W'(lvl_slot_next >> 3);

    lcpe_ram #(
        .WIDTH (lcpe_pkg::BYTE_W),
        .DEPTH (lcpe_pkg::FRAME_BYTES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (color_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // apply step: update counters and store, pick the position to report
    always_comb
    begin
        active_next     = active_reg;
        slot_next       = slot_reg;
        tick_next       = tick_reg;
        valid_next      = valid_reg;
        lvl_active_next = lvl_active_reg;
        lvl_slot_next   = lvl_slot_reg;
        lvl_tick_next   = lvl_tick_reg;
        ram_we          = 1'b0;

        if (state_reg == lcpe_pkg::ST_APPLY)
        begin
            lvl_active_next = active_reg;
            lvl_slot_next   = slot_reg;
            lvl_tick_next   = tick_reg;
            case (kind_reg)
                lcpe_pkg::KIND_TICK:
                begin
                    if (active_reg)
                    begin
                        // level is taken before the counters advance
                        if (tick_reg >= period)
                        begin
                            tick_next = '0;
                            if (slot_inc >= lcpe_pkg::SLOT_W'(lcpe_pkg::TOTAL_SLOTS))
                            begin
                                active_next = 1'b0;
                                slot_next   = '0;
                            end
                            else
                            begin
                                slot_next = slot_inc;
                            end
                        end
                        else
                        begin
                            tick_next = tick_reg + lcpe_pkg::TICK_W'(1);
                        end
                    end
                end
                lcpe_pkg::KIND_WRITE:
                begin
                    if (!active_reg &&
                        (32'(idx_reg) < lcpe_pkg::FRAME_BYTES))
                    begin
                        ram_we = 1'b1;
                        valid_next[ram_waddr] = 1'b1;
                    end
                end
                lcpe_pkg::KIND_START:
                begin
                    if (!active_reg)
                    begin
                        active_next     = 1'b1;
                        slot_next       = '0;
                        tick_next       = '0;
                        lvl_active_next = 1'b1;
                        lvl_slot_next   = '0;
                        lvl_tick_next   = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // valid bit of the byte read in the apply step
    always_comb
    begin
        rd_valid_next = rd_valid_reg;
        if (state_reg == lcpe_pkg::ST_APPLY)
        begin
            rd_valid_next = (32'(ram_raddr) < lcpe_pkg::FRAME_BYTES) ?
                            valid_reg[ram_raddr] : 1'b0;
        end
    end

    // level step: evaluate the bit from the registered read data
    always_comb
    begin
        bit_sel    = 3'd7 - lvl_slot_reg[2:0];
        data_bit   = rd_valid_reg && ram_rdata[bit_sel];
        high_ticks = data_bit ?
                     (fast_mode_reg ? lcpe_pkg::FAST_T1H : lcpe_pkg::SLOW_T1H) :
                     (fast_mode_reg ? lcpe_pkg::FAST_T0H : lcpe_pkg::SLOW_T0H);
        raw_level  = lvl_active_reg &&
                     (lvl_slot_reg < lcpe_pkg::SLOT_W'(lcpe_pkg::DATA_SLOTS)) &&
                     (lvl_tick_reg < high_ticks);
        done_next  = (state_reg == lcpe_pkg::ST_LEVEL);
        level_next = done_next ? (raw_level ^ invert_reg) : level_reg;
        ready_next = done_next ? !active_reg : ready_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lcpe_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = lcpe_pkg::ST_APPLY;
                end
            end
            lcpe_pkg::ST_APPLY: state_next = lcpe_pkg::ST_LEVEL;
            lcpe_pkg::ST_LEVEL: state_next = lcpe_pkg::ST_IDLE;
            default:            state_next = lcpe_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lcpe_pkg::ST_IDLE;
            fast_mode_reg  <= 1'b0;
            invert_reg     <= 1'b0;
            active_reg     <= 1'b0;
            slot_reg       <= '0;
            tick_reg       <= '0;
            valid_reg      <= '0;
            lvl_active_reg <= 1'b0;
            lvl_slot_reg   <= '0;
            lvl_tick_reg   <= '0;
            rd_valid_reg   <= 1'b0;
            done_reg       <= 1'b0;
            level_reg      <= 1'b0;
            ready_reg      <= 1'b1;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            slot_reg       <= slot_next;
            tick_reg       <= tick_next;
            valid_reg      <= valid_next;
            lvl_active_reg <= lvl_active_next;
            lvl_slot_reg   <= lvl_slot_next;
            lvl_tick_reg   <= lvl_tick_next;
            rd_valid_reg   <= rd_valid_next;
            done_reg       <= done_next;
            level_reg      <= level_next;
            ready_reg      <= ready_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    lcpe_pkg::CFG_FAST_MODE:       fast_mode_reg <= cfg_data[0];
                    lcpe_pkg::CFG_INVERT_POLARITY: invert_reg    <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind;
            idx_reg   <= byte_index;
            color_reg <= color_byte;
        end
    end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int RANDOM_ITEMS = 700;
    localparam int FRAME_TICKS = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic level;
        logic ready;
    } line_result_t;

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    logic                            done;
    logic [lcpe_pkg::KIND_W-1:0]     kind;
    logic [lcpe_pkg::INDEX_W-1:0]    byte_index;
    logic [lcpe_pkg::BYTE_W-1:0]     color_byte;
    logic                            line_level;
    logic                            ready_res;
    logic                            cfg_we;
    logic [lcpe_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lcpe_pkg::CFG_DATA_W-1:0] cfg_data;

    // shadow of the transmitter state
    logic [lcpe_pkg::BYTE_W-1:0] frame_mem [lcpe_pkg::FRAME_BYTES];
    logic              tx_busy;
    int                tx_slot;
    int                tx_tick;
    logic              cfg_fast;
    logic              cfg_invert;

    line_result_t pending_lines[$];
    int           mismatches;
    int           cycle_count;
    bit           steady;

    led_chain_pulse_encoder i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .done       (done),
        .kind       (kind),
        .byte_index (byte_index),
        .color_byte (color_byte),
        .line_level (line_level),
        .ready_res  (ready_res),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // line level before polarity at the current slot and tick
    function automatic logic raw_line();
        logic [lcpe_pkg::BYTE_W-1:0] cur;
        logic [lcpe_pkg::TICK_W-1:0] high_len;
        if (!tx_busy || tx_slot >= lcpe_pkg::DATA_SLOTS)
            return 1'b0;
        cur = frame_mem[tx_slot / 8];
        if (cur[7 - (tx_slot % 8)])
            high_len = cfg_fast ? lcpe_pkg::FAST_T1H : lcpe_pkg::SLOW_T1H;
        else
            high_len = cfg_fast ? lcpe_pkg::FAST_T0H : lcpe_pkg::SLOW_T0H;
        return tx_tick < int'(high_len);
    endfunction

    function automatic line_result_t next_line_state(
        input lcpe_pkg::kind_t k,
        input logic [lcpe_pkg::INDEX_W-1:0] idx,
        input logic [lcpe_pkg::BYTE_W-1:0] val);
        line_result_t res;
        logic         lvl;
        int           period;
        period = cfg_fast ? int'(lcpe_pkg::FAST_PERIOD) : int'(lcpe_pkg::SLOW_PERIOD);
        if (k == lcpe_pkg::KIND_TICK && tx_busy)
        begin
            // a tick reports the level it covers, then advances
            lvl = raw_line();
            if (tx_tick >= period)
            begin
                tx_tick = 0;
                tx_slot++;
                if (tx_slot >= lcpe_pkg::TOTAL_SLOTS)
                begin
                    tx_busy = 1'b0;
                    tx_slot = 0;
                end
            end
            else
            begin
                tx_tick++;
            end
        end
        else
        begin
            if (k == lcpe_pkg::KIND_WRITE && !tx_busy)
            begin
                if (idx < lcpe_pkg::FRAME_BYTES)
                    frame_mem[idx] = val;
            end
            else if (k == lcpe_pkg::KIND_START && !tx_busy)
            begin
                tx_busy = 1'b1;
                tx_slot = 0;
                tx_tick = 0;
            end
            lvl = raw_line();
        end
        res.level = lvl ^ cfg_invert;
        res.ready = !tx_busy;
        return res;
    endfunction

    task automatic send_item(input lcpe_pkg::kind_t k,
                             input logic [lcpe_pkg::INDEX_W-1:0] idx,
                             input logic [lcpe_pkg::BYTE_W-1:0] val);
        if (!steady && $urandom_range(99) < 11)
        begin
            start <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        start      <= 1'b1;
        kind       <= k;
        byte_index <= idx;
        color_byte <= val;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        // start stays high; the next call replaces the item before busy drops
        pending_lines.push_back(next_line_state(k, idx, val));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_lines.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_timing(input logic fast, input logic invert);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= lcpe_pkg::CFG_FAST_MODE;
        cfg_data  <= fast;
        @(posedge clk);
        cfg_index <= lcpe_pkg::CFG_INVERT_POLARITY;
        cfg_data  <= invert;
        @(posedge clk);
        cfg_we     <= 1'b0;
        cfg_fast   = fast;
        cfg_invert = invert;
    endtask

    // tick through part of the frame, with stray items mixed in
    task automatic run_out_frame(input int count);
        int              n;
        lcpe_pkg::kind_t k;
        n = 0;
        while (tx_busy && n < count)
        begin
            steady = (n >= 60 && n < 220);
            if ($urandom_range(99) < 3)
            begin
                k = ($urandom_range(2) == 0) ? lcpe_pkg::KIND_NONE :
                    lcpe_pkg::kind_t'($urandom_range(1));
                send_item(k, lcpe_pkg::INDEX_W'($urandom_range(63)),
                          lcpe_pkg::BYTE_W'($urandom_range(255)));
            end
            else
            begin
                send_item(lcpe_pkg::KIND_TICK, lcpe_pkg::INDEX_W'($urandom_range(63)),
                          lcpe_pkg::BYTE_W'($urandom_range(255)));
            end
            n++;
        end
        steady = 1'b0;
    endtask

    task automatic test_idle_behavior();
        send_item(lcpe_pkg::KIND_NONE, '0, '0);
        send_item(lcpe_pkg::KIND_TICK, '0, '0);
        send_item(lcpe_pkg::KIND_WRITE, 6'd0, 8'hFF);
        send_item(lcpe_pkg::KIND_WRITE, 6'd1, 8'h00);
        send_item(lcpe_pkg::KIND_WRITE, 6'd59, 8'h80);
        // indexes past the frame are dropped
        send_item(lcpe_pkg::KIND_WRITE, 6'd60, 8'h5A);
        send_item(lcpe_pkg::KIND_WRITE, 6'd63, 8'hFF);
        send_item(lcpe_pkg::KIND_NONE, 6'd63, 8'hFF);
        set_timing(1'b0, 1'b1);
        send_item(lcpe_pkg::KIND_NONE, '0, '0);
        send_item(lcpe_pkg::KIND_TICK, 6'd63, 8'hFF);
        send_item(lcpe_pkg::KIND_WRITE, 6'd2, 8'h01);
    endtask

    task automatic test_frame(input logic fast, input logic invert);
        logic [lcpe_pkg::BYTE_W-1:0] val;
        set_timing(fast, invert);
        for (int i = 0; i < lcpe_pkg::FRAME_BYTES; i++)
        begin
            if (i == 0)
                val = 8'hFF;
            else if (i == 1)
                val = 8'h00;
            else
                val = lcpe_pkg::BYTE_W'($urandom_range(255));
            send_item(lcpe_pkg::KIND_WRITE, lcpe_pkg::INDEX_W'(i), val);
        end
        send_item(lcpe_pkg::KIND_START, '0, '0);
        // these must not disturb the frame in flight
        send_item(lcpe_pkg::KIND_START, '0, '0);
        send_item(lcpe_pkg::KIND_WRITE, 6'd0, 8'h33);
        send_item(lcpe_pkg::KIND_NONE, 6'd0, 8'h00);
        run_out_frame(FRAME_TICKS);
    endtask

    task automatic test_random_items();
        lcpe_pkg::kind_t k;
        int              roll;
        set_timing(1'b1, 1'b1);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
                drain_results();
            steady = (n >= 200 && n < 500);
            roll = $urandom_range(99);
            if (tx_busy)
                k = (roll < 88) ? lcpe_pkg::KIND_TICK : lcpe_pkg::kind_t'($urandom_range(3));
            else if (roll < 67)
                k = lcpe_pkg::KIND_WRITE;
            else if (roll < 70)
                k = lcpe_pkg::KIND_START;
            else if (roll < 85)
                k = lcpe_pkg::KIND_TICK;
            else
                k = lcpe_pkg::KIND_NONE;
            send_item(k, lcpe_pkg::INDEX_W'($urandom_range(63)),
                      lcpe_pkg::BYTE_W'($urandom_range(255)));
        end
        steady = 1'b0;
    endtask

    always @(posedge clk)
    begin
        line_result_t want;
        if (done === 1'b1)
        begin
            if (pending_lines.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with no item pending: level %b ready %b",
                             $realtime, line_level, ready_res);
            end
            else
            begin
                want = pending_lines.pop_front();
                if (line_level !== want.level)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: line_level expected %b got %b",
                                 $realtime, want.level, line_level);
                end
                if (ready_res !== want.ready)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: ready_res expected %b got %b",
                                 $realtime, want.ready, ready_res);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial
    begin
        start      <= 1'b0;
        kind       <= lcpe_pkg::KIND_NONE;
        byte_index <= '0;
        color_byte <= '0;
        cfg_we     <= 1'b0;
        cfg_index  <= lcpe_pkg::CFG_FAST_MODE;
        cfg_data   <= '0;
        rst_n      <= 1'b0;
        for (int i = 0; i < lcpe_pkg::FRAME_BYTES; i++)
            frame_mem[i] = '0;
        tx_busy     = 1'b0;
        tx_slot     = 0;
        tx_tick     = 0;
        cfg_fast    = 1'b0;
        cfg_invert  = 1'b0;
        mismatches  = 0;
        cycle_count = 0;
        steady      = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_behavior();
        test_frame(1'b1, 1'b0);
        test_frame(1'b0, 1'b1);
        test_random_items();
        drain_results();

        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
